[rtl/jchc_pkg.sv]
// jchc_pkg: shared types and constants of the jump chain hop counter
// used by jchc_tables, jump_chain_hop_counter and tb_jump_chain_hop_counter
package jchc_pkg;

    localparam int IDX_W       = 10;
    localparam int JUMP_W      = 11;
    localparam int N_W         = 11;
    localparam int HOPS_W      = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [HOPS_W-1:0] HOPS_MAX = {HOPS_W{1'b1}};

    typedef enum logic {
        CMD_SET   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_BUILD,
        ST_LINK,
        ST_QUERY,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic jump_we;
        logic link_we;
    } tbl_wen_t;

endpackage

[rtl/jchc_rem_unit.sv]
// jchc_rem_unit: remainder of an entry index by the block length
// reciprocal multiply for the quotient, then back-multiply and one correction; depends on nothing
module jchc_rem_unit #(
    parameter int DIVIDEND_W = 10,
    parameter int DIVISOR    = 32,
    parameter int REM_W      = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [REM_W-1:0]      rem
);

    localparam int DVW   = $clog2(DIVISOR + 1);
    localparam int CW    = ((DIVIDEND_W > DVW) ? DIVIDEND_W : DVW) + 1;
    localparam int PRW   = 2 * DIVIDEND_W;
    localparam int RECIP = (1 << DIVIDEND_W) / DIVISOR;

    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic                  busy_reg;
    logic [REM_W-1:0]      rem_reg;
    logic                  done_reg;
    logic [PRW-1:0]        prod;
    logic [CW-1:0]         back;
    logic [CW-1:0]         diff;
    logic [CW-1:0]         rem_fix;

    // quotient estimate is exact or one low, so one conditional subtract is enough
    always_comb begin
        prod = PRW'(dividend) * PRW'(RECIP);
        back = CW'(quot_reg) * CW'(DIVISOR);
        diff = CW'(dvd_reg) - back;
        if (diff >= CW'(DIVISOR)) begin
            rem_fix = diff - CW'(DIVISOR);
        end else begin
            rem_fix = diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            quot_reg <= DIVIDEND_W'(prod >> DIVIDEND_W);
        end
        if (busy_reg) begin
            rem_reg <= REM_W'(rem_fix);
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/jchc_tables.sv]
// jchc_tables: jump length memory and per-entry link memory (steps, landing)
// one write and one registered read port each; uses jchc_pkg
module jchc_tables #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int STEP_W = 6,
    parameter int POS_W  = 11
) (
    input  logic                         aclk,
    input  jchc_pkg::tbl_wen_t           wen,
    input  logic [ADDR_W-1:0]            jump_waddr,
    input  logic [jchc_pkg::JUMP_W-1:0]  jump_wdata,
    input  logic [ADDR_W-1:0]            jump_raddr,
    output logic [jchc_pkg::JUMP_W-1:0]  jump_rdata,
    input  logic [ADDR_W-1:0]            link_waddr,
    input  logic [STEP_W-1:0]            link_wsteps,
    input  logic [POS_W-1:0]             link_wland,
    input  logic [ADDR_W-1:0]            link_raddr,
    output logic [STEP_W-1:0]            link_rsteps,
    output logic [POS_W-1:0]             link_rland
);

    import jchc_pkg::*;

    logic [JUMP_W-1:0]       jump_mem [DEPTH];
    logic [STEP_W+POS_W-1:0] link_mem [DEPTH];
    logic [JUMP_W-1:0]       jump_rd_reg;
    logic [STEP_W+POS_W-1:0] link_rd_reg;

    always_ff @(posedge aclk) begin
        if (wen.jump_we) begin
            jump_mem[jump_waddr] <= jump_wdata;
        end
        jump_rd_reg <= jump_mem[jump_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wen.link_we) begin
            link_mem[link_waddr] <= {link_wsteps, link_wland};
        end
        link_rd_reg <= link_mem[link_raddr];
    end

    assign jump_rdata  = jump_rd_reg;
    assign link_rsteps = link_rd_reg[STEP_W+POS_W-1:POS_W];
    assign link_rland  = link_rd_reg[POS_W-1:0];

endmodule

[rtl/jump_chain_hop_counter.sv]
// jump_chain_hop_counter: top level, sequencer over the link tables and remainder unit
// uses jchc_pkg, jchc_rem_unit and jchc_tables
//
//  channel  | dir | handshake             | contents
//  ---------+-----+-----------------------+------------------------------------------
//  s_       | in  | s_tvalid / s_tready   | tuser: cmd; tdata: index, jump
//  m_       | out | m_tvalid / m_tready   | tdata: hops
//  cfg_     | in  | cfg_we                | cfg_wdata: entries_in_use
//
// set: the remainder unit gives the block offset, then each entry from index down to its
//   block start (at most BLOCK_LEN entries) is rebuilt, with one link memory write each
// query: one link memory read per block crossed
// reset: every jump memory entry is set to 1, then a full rebuild as after a cfg write;
//   s_tready is low meanwhile
// a result waiting on m_ does not block the next request
module jump_chain_hop_counter #(
    parameter int TABLE_DEPTH = 1024,
    parameter int BLOCK_LEN   = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [jchc_pkg::IN_TDATA_W-1:0]    s_tdata,   // index[9:0], jump[20:10]
    input  logic [0:0]                         s_tuser,   // cmd[0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [jchc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // hops[10:0]
    input  logic                               cfg_we,
    input  logic [jchc_pkg::N_W-1:0]           cfg_wdata
);

    import jchc_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int PW  = $clog2(TABLE_DEPTH + 1);
    localparam int TW  = ((PW > JUMP_W) ? PW : JUMP_W) + 1;
    localparam int SW  = $clog2(BLOCK_LEN + 1);
    localparam int OFW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

    state_t            state_reg, state_next;
    logic              pend_reg, pend_next;
    logic [PW-1:0]     n_reg, n_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [OFW-1:0]    off_reg, off_next;
    logic [TW-1:0]     blk_end_reg, blk_end_next;
    logic              all_reg, all_next;
    logic [HOPS_W-1:0] hops_reg, hops_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [HOPS_W-1:0] m_hops_reg, m_hops_next;

    tbl_wen_t          wen;
    logic [AW-1:0]     jump_waddr;
    logic [JUMP_W-1:0] jump_wdata;
    logic [JUMP_W-1:0] jump_rdata;
    logic [AW-1:0]     link_raddr;
    logic [SW-1:0]     link_wsteps;
    logic [PW-1:0]     link_wland;
    logic [SW-1:0]     link_rsteps;
    logic [PW-1:0]     link_rland;

    logic              rem_start;
    logic              rem_done;
    logic [OFW-1:0]    rem_val;

    logic [IDX_W-1:0]  in_idx;
    logic [JUMP_W-1:0] in_jump;
    cmd_t              in_cmd;
    logic [TW-1:0]     in_idx_w;
    logic [TW-1:0]     n_w;
    logic [TW-1:0]     t_w;
    logic              t_exit;
    logic [PW-1:0]     t_land;
    logic [HOPS_W:0]   hops_sum;
    logic [HOPS_W-1:0] hops_sat;
    logic [TW-1:0]     cfg_w;
    logic [TW-1:0]     cfg_val;
    logic              walk_last;
    logic              advance;

    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_jump  = s_tdata[IDX_W +: JUMP_W];
    assign in_cmd   = cmd_t'(s_tuser[0]);
    assign in_idx_w = TW'(in_idx);
    assign n_w      = TW'(n_reg);
    assign t_w      = TW'(i_reg) + TW'(jump_rdata);
    assign t_exit   = (t_w >= blk_end_reg) || (t_w >= n_w);
    assign t_land   = (t_w < n_w) ? t_w[PW-1:0] : n_reg;
    assign hops_sum = (HOPS_W+1)'(hops_reg) + (HOPS_W+1)'(link_rsteps);
    assign hops_sat = hops_sum[HOPS_W] ? HOPS_MAX : hops_sum[HOPS_W-1:0];
    assign walk_last = all_reg ? (i_reg == '0) : (off_reg == '0);
    assign cfg_w    = TW'(cfg_wdata);

    always_comb begin
        if (cfg_w == '0) begin
            cfg_val = TW'(1);
        end else if (cfg_w > TW'(TABLE_DEPTH)) begin
            cfg_val = TW'(TABLE_DEPTH);
        end else begin
            cfg_val = cfg_w;
        end
    end

    jchc_rem_unit #(
        .DIVIDEND_W (AW),
        .DIVISOR    (BLOCK_LEN),
        .REM_W      (OFW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (i_next),
        .done     (rem_done),
        .rem      (rem_val)
    );

    jchc_tables #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW),
        .STEP_W (SW),
        .POS_W  (PW)
    ) u_tables (
        .aclk        (aclk),
        .wen         (wen),
        .jump_waddr  (jump_waddr),
        .jump_wdata  (jump_wdata),
        .jump_raddr  (i_next),
        .jump_rdata  (jump_rdata),
        .link_waddr  (i_reg),
        .link_wsteps (link_wsteps),
        .link_wland  (link_wland),
        .link_raddr  (link_raddr),
        .link_rsteps (link_rsteps),
        .link_rland  (link_rland)
    );

    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        off_next      = off_reg;
        blk_end_next  = blk_end_reg;
        all_next      = all_reg;
        hops_next     = hops_reg;
        m_hops_next   = m_hops_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        wen           = '0;
        jump_waddr    = i_reg;
        jump_wdata    = JUMP_W'(1);
        link_raddr    = t_w[AW-1:0];
        link_wsteps   = SW'(1);
        link_wland    = t_land;
        rem_start     = 1'b0;
        advance       = 1'b0;

        unique case (state_reg)
            ST_INIT: begin
                wen.jump_we = 1'b1;
                if (i_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    i_next = i_reg - AW'(1);
                end
            end
            ST_IDLE: begin
                link_raddr = in_idx_w[AW-1:0];
                if (pend_reg) begin
                    pend_next  = 1'b0;
                    i_next     = n_reg[AW-1:0] - AW'(1);
                    all_next   = 1'b1;
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end else if (s_tvalid) begin
                    if (in_cmd == CMD_SET) begin
                        if (in_idx_w < TW'(TABLE_DEPTH)) begin
                            wen.jump_we = 1'b1;
                            jump_waddr  = in_idx_w[AW-1:0];
                            jump_wdata  = (in_jump == '0) ? JUMP_W'(1) : in_jump;
                            if (in_idx_w < n_w) begin
                                i_next     = in_idx_w[AW-1:0];
                                all_next   = 1'b0;
                                rem_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                    end else begin
                        hops_next = '0;
                        if (in_idx_w >= n_w) begin
                            state_next = ST_REPLY;
                        end else begin
                            state_next = ST_QUERY;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (rem_done) begin
                    off_next     = rem_val;
                    blk_end_next = TW'(i_reg) - TW'(rem_val) + TW'(BLOCK_LEN);
                    state_next   = ST_BUILD;
                end
            end
            ST_BUILD: begin
                if (t_exit) begin
                    wen.link_we = 1'b1;
                    advance     = 1'b1;
                end else begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                wen.link_we = 1'b1;
                link_wsteps = link_rsteps + SW'(1);
                link_wland  = link_rland;
                advance     = 1'b1;
            end
            ST_QUERY: begin
                hops_next = hops_sat;
                if (TW'(link_rland) >= n_w) begin
                    state_next = ST_REPLY;
                end else begin
                    link_raddr = link_rland[AW-1:0];
                end
            end
            ST_REPLY: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_hops_next   = hops_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance) begin
            if (walk_last) begin
                state_next = ST_IDLE;
            end else begin
                i_next     = i_reg - AW'(1);
                state_next = ST_BUILD;
                if (off_reg == '0) begin
                    off_next     = OFW'(BLOCK_LEN - 1);
                    blk_end_next = blk_end_reg - TW'(BLOCK_LEN);
                end else begin
                    off_next = off_reg - OFW'(1);
                end
            end
        end

        if (cfg_we) begin
            n_next    = cfg_val[PW-1:0];
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            pend_reg     <= 1'b1;
            n_reg        <= PW'(TABLE_DEPTH);
            i_reg        <= AW'(TABLE_DEPTH - 1);
            all_reg      <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            n_reg        <= n_next;
            i_reg        <= i_next;
            all_reg      <= all_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg     <= off_next;
        blk_end_reg <= blk_end_next;
        hops_reg    <= hops_next;
        m_hops_reg  <= m_hops_next;
    end

    assign s_tready = (state_reg == ST_IDLE) && !pend_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_hops_reg);

    // block bookkeeping stays consistent with the entry being rebuilt
    a_block_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUILD || state_reg == ST_LINK) |->
            (TW'(i_reg) + TW'(BLOCK_LEN) == blk_end_reg + TW'(off_reg)))
        else $error("block end and offset out of step with entry index");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_REPLY))
        else $error("result raised outside reply state");

    a_rem_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == ST_DIV))
        else $error("remainder finished outside divide state");

endmodule

[tb/tb_jump_chain_hop_counter.sv]
// tb_jump_chain_hop_counter: self-checking testbench for the jump chain hop counter
// directed table then random set and query requests, checked against a jump-walk predictor
// depends on jchc_pkg and jump_chain_hop_counter
`timescale 1ns / 1ps

module tb_jump_chain_hop_counter;
    import jchc_pkg::*;

    localparam int TABLE_DEPTH     = 1024;
    localparam int BLOCK_LEN       = 32;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 134;
    localparam int SETTLE_CYCLES   = 200;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DIR_ROWS        = 25;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        cmd_t              cmd;
        logic [IDX_W-1:0]  index;
        logic [JUMP_W-1:0] value;
        logic              typed;
        logic [HOPS_W-1:0] hops;
    } step_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [N_W-1:0]         cfg_wdata = '0;

    logic [JUMP_W-1:0] jump_len [TABLE_DEPTH];
    int unsigned       n_used;
    logic [HOPS_W-1:0] expected_hops [$];

    int  mismatches   = 0;
    int  query_count  = 0;
    int  set_count    = 0;
    int  result_count = 0;
    int  cfg_count    = 0;
    int  idle_cycles  = 0;
    bit  idle_on      = 1'b1;
    bit  hold_req     = 1'b0;

    logic [N_W-1:0] phase_sizes [NUM_PHASES] = '{
        11'd37, 11'd1, 11'd1024, 11'd33, 11'd2047, 11'd2,
        11'd500, 11'd0, 11'd31, 11'd64, 11'd1025, 11'd1000
    };

    // index, jump in value; cfg rows carry the register value in value
    step_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_REQ, CMD_QUERY, 10'd0,    11'd0,    1'b1, 11'd1024},
        '{ROW_REQ, CMD_QUERY, 10'd1023, 11'd0,    1'b1, 11'd1},
        '{ROW_REQ, CMD_QUERY, 10'd512,  11'd0,    1'b1, 11'd512},
        '{ROW_REQ, CMD_SET,   10'd1023, 11'd0,    1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd1023, 11'd0,    1'b1, 11'd1},
        '{ROW_REQ, CMD_SET,   10'd0,    11'd2047, 1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd0,    11'd0,    1'b1, 11'd1},
        '{ROW_REQ, CMD_SET,   10'd0,    11'd1023, 1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd0,    11'd0,    1'b1, 11'd2},
        '{ROW_REQ, CMD_SET,   10'd31,   11'd1000, 1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd30,   11'd0,    1'b0, 11'd0},
        '{ROW_REQ, CMD_SET,   10'd5,    11'd26,   1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd1,    11'd0,    1'b0, 11'd0},
        '{ROW_CFG, CMD_SET,   10'd0,    11'd1,    1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd0,    11'd0,    1'b1, 11'd1},
        '{ROW_REQ, CMD_QUERY, 10'd1,    11'd0,    1'b1, 11'd0},
        '{ROW_REQ, CMD_SET,   10'd1023, 11'd5,    1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd1023, 11'd0,    1'b1, 11'd0},
        '{ROW_CFG, CMD_SET,   10'd0,    11'd0,    1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd0,    11'd0,    1'b1, 11'd1},
        '{ROW_CFG, CMD_SET,   10'd0,    11'd2047, 1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd1023, 11'd0,    1'b1, 11'd1},
        '{ROW_REQ, CMD_QUERY, 10'd0,    11'd0,    1'b1, 11'd2},
        '{ROW_REQ, CMD_SET,   10'd512,  11'd1024, 1'b0, 11'd0},
        '{ROW_REQ, CMD_QUERY, 10'd480,  11'd0,    1'b0, 11'd0}
    };

    jump_chain_hop_counter #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .BLOCK_LEN  (BLOCK_LEN)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(string what, logic [OUT_TDATA_W-1:0] got,
                                   logic [OUT_TDATA_W-1:0] want);
        $display("[%0t] mismatch: %s, got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // walk the chain one jump at a time until the position leaves the table
    function automatic logic [HOPS_W-1:0] hops_to_exit(int unsigned start);
        int unsigned pos;
        int unsigned count;
        pos   = start;
        count = 0;
        while (pos < n_used) begin
            pos   = pos + jump_len[pos];
            count = count + 1;
        end
        if (count > HOPS_MAX)
            count = HOPS_MAX;
        return count[HOPS_W-1:0];
    endfunction

    task automatic issue_request(cmd_t cmd, logic [IDX_W-1:0] index, logic [JUMP_W-1:0] jmp,
                                 logic typed, logic [HOPS_W-1:0] typed_hops);
        int unsigned gap;
        gap = idle_on ? $urandom_range(11, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_TDATA_W - IDX_W - JUMP_W){1'b0}}, jmp, index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_QUERY) begin
            expected_hops.push_back(typed ? typed_hops : hops_to_exit(index));
            query_count++;
        end else begin
            jump_len[index] = (jmp == '0) ? JUMP_W'(1) : jmp;
            set_count++;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_hops.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_entries(logic [N_W-1:0] wdata);
        drain_results();
        // a trailing set may still be rebuilding its block
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wdata <= wdata;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (wdata == '0)
            n_used = 1;
        else if (wdata > TABLE_DEPTH)
            n_used = TABLE_DEPTH;
        else
            n_used = wdata;
        cfg_count++;
    endtask

    // result side
    initial begin : result_sink
        int unsigned wait_cycles;
        logic [HOPS_W-1:0] want;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            wait_cycles = idle_on ? $urandom_range(11, 0) : 0;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            result_count++;
            if (expected_hops.size() == 0) begin
                report_mismatch("hops result with no query pending", m_tdata, '0);
            end else begin
                want = expected_hops.pop_front();
                if (m_tdata !== {{(OUT_TDATA_W - HOPS_W){1'b0}}, want})
                    report_mismatch("hops", m_tdata, {{(OUT_TDATA_W - HOPS_W){1'b0}}, want});
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL jump_chain_hop_counter");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cmd_t              cmd;
        logic [IDX_W-1:0]  index;
        logic [JUMP_W-1:0] jmp;
        int unsigned       pick;
        for (int i = 0; i < TABLE_DEPTH; i++)
            jump_len[i] = JUMP_W'(1);
        n_used = TABLE_DEPTH;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_entries(directed_rows[r].value);
            else
                issue_request(directed_rows[r].cmd, directed_rows[r].index,
                              directed_rows[r].value, directed_rows[r].typed,
                              directed_rows[r].hops);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_entries(phase_sizes[p]);
            idle_on = (p % 3) != 1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // receiver stalls while the sender keeps pushing
                if (p == 2 && k == 20) begin
                    idle_on  = 1'b0;
                    hold_req = 1'b1;
                end
                if (p == 2 && k == 90)
                    idle_on = 1'b1;
                if (p == 5 && k == ITEMS_PER_PHASE / 2)
                    drain_results();
                cmd = ($urandom_range(1, 0) == 1) ? CMD_QUERY : CMD_SET;
                if ($urandom_range(4, 0) != 0)
                    index = IDX_W'($urandom_range(n_used - 1, 0));
                else
                    index = IDX_W'($urandom_range(TABLE_DEPTH - 1, 0));
                pick = $urandom_range(99, 0);
                if (pick < 60)
                    jmp = JUMP_W'($urandom_range(4, 1));
                else if (pick < 85)
                    jmp = JUMP_W'($urandom_range(64, 1));
                else if (pick < 95)
                    jmp = JUMP_W'($urandom_range(2047, 0));
                else
                    jmp = '0;
                issue_request(cmd, index, jmp, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_hops.size() != 0)
            report_mismatch("queries left without a result", OUT_TDATA_W'(expected_hops.size()),
                            '0);

        $display("covered %0d queries and %0d sets over %0d table size writes",
                 query_count, set_count, cfg_count);
        $display("checked %0d hop results, %0d mismatches", result_count, mismatches);
        if (mismatches == 0)
            $display("PASS jump_chain_hop_counter");
        else
            $display("FAIL jump_chain_hop_counter");
        $finish;
    end

endmodule
